// File: hw/rtl/seconds_to_calendar_date_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the seconds to calendar date block
// Clocked property checks, with and without the reset qualifier.
// ---------------------------------------------------------------------------
`ifndef SECONDS_TO_CALENDAR_DATE_ASSERT_SVH
`define SECONDS_TO_CALENDAR_DATE_ASSERT_SVH

// Check a property while out of reset
`define S2CD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every edge, reset included
`define S2CD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: hw/rtl/s2cd_pkg.sv
// ---------------------------------------------------------------------------
// s2cd_pkg
// Shared widths, calendar constants and the month length table.
// ---------------------------------------------------------------------------
`default_nettype none

package s2cd_pkg;

    localparam int DataW    = 32;   // seconds datapath
    localparam int YearW    = 14;   // year port width
    localparam int YearExtW = 15;   // year while counting, room for carry past 16383
    localparam int DayW     = 9;    // day of year, 0..365
    localparam int StepW    = 4;    // step counter of the divide phases

    localparam logic [DataW-1:0] SecsLeapYear   = 32'd31622400;
    localparam logic [DataW-1:0] SecsCommonYear = 32'd31536000;
    localparam logic [DataW-1:0] SecsPerDay     = 32'd86400;
    localparam logic [DataW-1:0] SecsPerHour    = 32'd3600;
    localparam logic [DataW-1:0] SecsPerMin     = 32'd60;

    localparam int Year400      = 400;
    localparam int CenturyYears = 100;
    localparam int FebLeapDays  = 29;

    localparam logic [YearW-1:0] EpochReset = 14'd2000;

    // Top shift of each restoring divide phase
    localparam logic [StepW-1:0] YmodTopStep  = 4'd5;  // 400 << 5 still below 16384
    localparam logic [StepW-1:0] Ym100TopStep = 4'd1;  // remainder < 400, 100 << 1
    localparam logic [StepW-1:0] DayTopStep   = 4'd8;  // day of year < 512
    localparam logic [StepW-1:0] HourTopStep  = 4'd4;  // hour < 32
    localparam logic [StepW-1:0] MinTopStep   = 4'd5;  // minute < 64

    localparam logic [3:0] FebIdx       = 4'd1;
    localparam logic [3:0] LastMonthIdx = 4'd11;

    // Days in month m (0 is January)
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
            4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
            4'd1:    len = leap ? 5'(FebLeapDays) : 5'd28;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/s2cd_cmp_sub.sv
// ---------------------------------------------------------------------------
// s2cd_cmp_sub
// Shared compare and subtract unit: reports a >= b and gives a - b.
// ---------------------------------------------------------------------------
`default_nettype none

module s2cd_cmp_sub (
    input  wire logic [s2cd_pkg::DataW-1:0] i_a,
    input  wire logic [s2cd_pkg::DataW-1:0] i_b,
    output logic                            o_ge,
    output logic [s2cd_pkg::DataW-1:0]      o_diff
);

    logic [s2cd_pkg::DataW:0] diff_ext;

    // Borrow out of the wide subtract flags a < b
    assign diff_ext = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge     = ~diff_ext[s2cd_pkg::DataW];
    assign o_diff   = diff_ext[s2cd_pkg::DataW-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/seconds_to_calendar_date.sv
// Accept leads to the result strobe once the sequencer has taken off Y whole
// years and M whole months (Y <= 136, M <= 11); one compare/subtract unit
// does every step. One item at a time: a new one is taken only while idle,
// and busy falls with the strobe.
// The receiver cannot stall; each result shows for one cycle.
// Reset: synchronous, active low; clears control and sets epoch_year to 2000.
// ---------------------------------------------------------------------------
// seconds_to_calendar_date
// Converts seconds since the epoch year to year, month, day, hour, minute
// and second by repeated compare and subtract under a small sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module seconds_to_calendar_date (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [13:0] i_cfg_wr_data,
    input  wire logic        start,
    input  wire logic [31:0] i_elapsed_seconds,
    output logic             busy,
    output logic             o_result_valid,
    output logic [13:0]      o_cal_year,
    output logic [3:0]       o_cal_month,
    output logic [4:0]       o_cal_day,
    output logic [4:0]       o_cal_hour,
    output logic [5:0]       o_cal_minute,
    output logic [5:0]       o_cal_second
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YMOD,
        ST_YM100,
        ST_YEAR,
        ST_DAY,
        ST_MON,
        ST_HOUR,
        ST_MIN
    } t_state;

    localparam int DW = s2cd_pkg::DataW;

    t_state                          r_state,  n_state;
    logic [s2cd_pkg::YearW-1:0]      r_epoch,  n_epoch;
    logic [DW-1:0]                   r_rem,    n_rem;
    logic [s2cd_pkg::YearExtW-1:0]   r_year,   n_year;
    logic [s2cd_pkg::YearW-1:0]      r_ywork,  n_ywork;
    logic [8:0]                      r_y400,   n_y400;
    logic [6:0]                      r_y100,   n_y100;
    logic [s2cd_pkg::StepW-1:0]      r_step,   n_step;
    logic [s2cd_pkg::DayW-1:0]       r_quot,   n_quot;
    logic [3:0]                      r_month,  n_month;
    logic [4:0]                      r_hour,   n_hour;
    logic [5:0]                      r_min,    n_min;
    logic                            r_valid,  n_valid;
    logic [13:0]                     r_cal_year,   n_cal_year;
    logic [3:0]                      r_cal_month,  n_cal_month;
    logic [4:0]                      r_cal_day,    n_cal_day;
    logic [4:0]                      r_cal_hour,   n_cal_hour;
    logic [5:0]                      r_cal_minute, n_cal_minute;
    logic [5:0]                      r_cal_second, n_cal_second;

    logic [DW-1:0] op_a;
    logic [DW-1:0] op_b;
    logic [DW-1:0] op_diff;
    logic          op_ge;
    logic          is_leap;

    s2cd_cmp_sub u_cmp_sub (
        .i_a    (op_a),
        .i_b    (op_b),
        .o_ge   (op_ge),
        .o_diff (op_diff)
    );

    // Leap rule from the tracked residues of the current year
    assign is_leap = ((r_year[1:0] == 2'd0) && (r_y100 != 7'd0)) || (r_y400 == 9'd0);

    // Sequencer: pick operands for the shared unit and advance
    always_comb begin
        n_state      = r_state;
        n_epoch      = r_epoch;
        n_rem        = r_rem;
        n_year       = r_year;
        n_ywork      = r_ywork;
        n_y400       = r_y400;
        n_y100       = r_y100;
        n_step       = r_step;
        n_quot       = r_quot;
        n_month      = r_month;
        n_hour       = r_hour;
        n_min        = r_min;
        n_valid      = 1'b0;
        n_cal_year   = r_cal_year;
        n_cal_month  = r_cal_month;
        n_cal_day    = r_cal_day;
        n_cal_hour   = r_cal_hour;
        n_cal_minute = r_cal_minute;
        n_cal_second = r_cal_second;
        op_a         = r_rem;
        op_b         = s2cd_pkg::SecsPerDay;

        if (i_cfg_wr_en) begin
            n_epoch = i_cfg_wr_data;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_YMOD;
                    n_rem   = i_elapsed_seconds;
                    n_year  = {1'b0, r_epoch};
                    n_ywork = r_epoch;
                    n_step  = s2cd_pkg::YmodTopStep;
                end
            end

            // Epoch year mod 400 by restoring division
            ST_YMOD: begin
                op_a = DW'(r_ywork);
                op_b = DW'(s2cd_pkg::Year400) << r_step;
                if (op_ge) begin
                    n_ywork = op_diff[s2cd_pkg::YearW-1:0];
                end
                if (r_step == '0) begin
                    n_y400  = n_ywork[8:0];
                    n_state = ST_YM100;
                    n_step  = s2cd_pkg::Ym100TopStep;
                end else begin
                    n_step = r_step - 4'd1;
                end
            end

            // Reduce the mod-400 residue to mod 100
            ST_YM100: begin
                op_a = DW'(r_ywork);
                op_b = DW'(s2cd_pkg::CenturyYears) << r_step;
                if (op_ge) begin
                    n_ywork = op_diff[s2cd_pkg::YearW-1:0];
                end
                if (r_step == '0) begin
                    n_y100  = n_ywork[6:0];
                    n_state = ST_YEAR;
                end else begin
                    n_step = r_step - 4'd1;
                end
            end

            // Take off whole years, one per cycle
            ST_YEAR: begin
                op_a = r_rem;
                op_b = is_leap ? s2cd_pkg::SecsLeapYear : s2cd_pkg::SecsCommonYear;
                if (op_ge) begin
                    n_rem  = op_diff;
                    n_year = r_year + 15'd1;
                    n_y400 = (r_y400 == 9'(s2cd_pkg::Year400 - 1)) ? 9'd0 : r_y400 + 9'd1;
                    n_y100 = (r_y100 == 7'(s2cd_pkg::CenturyYears - 1)) ?
                             7'd0 : r_y100 + 7'd1;
                end else begin
                    n_state = ST_DAY;
                    n_step  = s2cd_pkg::DayTopStep;
                    n_quot  = '0;
                end
            end

            // Day of year and seconds of day
            ST_DAY: begin
                op_a = r_rem;
                op_b = s2cd_pkg::SecsPerDay << r_step;
                if (op_ge) begin
                    n_rem = op_diff;
                end
                n_quot = {r_quot[s2cd_pkg::DayW-2:0], op_ge};
                if (r_step == '0) begin
                    n_state = ST_MON;
                    n_month = '0;
                end else begin
                    n_step = r_step - 4'd1;
                end
            end

            // Take off whole months; December takes the rest
            ST_MON: begin
                op_a = DW'(r_quot);
                op_b = DW'(s2cd_pkg::month_len(r_month,
                                               is_leap && (r_month == s2cd_pkg::FebIdx)));
                if ((r_month == s2cd_pkg::LastMonthIdx) || !op_ge) begin
                    n_state = ST_HOUR;
                    n_step  = s2cd_pkg::HourTopStep;
                    n_hour  = '0;
                end else begin
                    n_quot  = op_diff[s2cd_pkg::DayW-1:0];
                    n_month = r_month + 4'd1;
                end
            end

            ST_HOUR: begin
                op_a = r_rem;
                op_b = s2cd_pkg::SecsPerHour << r_step;
                if (op_ge) begin
                    n_rem = op_diff;
                end
                n_hour = {r_hour[3:0], op_ge};
                if (r_step == '0) begin
                    n_state = ST_MIN;
                    n_step  = s2cd_pkg::MinTopStep;
                    n_min   = '0;
                end else begin
                    n_step = r_step - 4'd1;
                end
            end

            // Minutes; the remainder is the second, then publish the item
            ST_MIN: begin
                op_a = r_rem;
                op_b = s2cd_pkg::SecsPerMin << r_step;
                if (op_ge) begin
                    n_rem = op_diff;
                end
                n_min = {r_min[4:0], op_ge};
                if (r_step == '0) begin
                    n_state      = ST_IDLE;
                    n_valid      = 1'b1;
                    n_cal_year   = r_year[s2cd_pkg::YearW-1:0];
                    n_cal_month  = r_month + 4'd1;
                    n_cal_day    = r_quot[4:0] + 5'd1;
                    n_cal_hour   = r_hour;
                    n_cal_minute = n_min;
                    n_cal_second = n_rem[5:0];
                end else begin
                    n_step = r_step - 4'd1;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state, working registers and the registered result
    always_ff @(posedge i_clk) begin
        r_rem        <= n_rem;
        r_year       <= n_year;
        r_ywork      <= n_ywork;
        r_y400       <= n_y400;
        r_y100       <= n_y100;
        r_step       <= n_step;
        r_quot       <= n_quot;
        r_month      <= n_month;
        r_hour       <= n_hour;
        r_min        <= n_min;
        r_cal_year   <= n_cal_year;
        r_cal_month  <= n_cal_month;
        r_cal_day    <= n_cal_day;
        r_cal_hour   <= n_cal_hour;
        r_cal_minute <= n_cal_minute;
        r_cal_second <= n_cal_second;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_epoch <= s2cd_pkg::EpochReset;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_epoch <= n_epoch;
        end
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_valid;
    assign o_cal_year     = r_cal_year;
    assign o_cal_month    = r_cal_month;
    assign o_cal_day      = r_cal_day;
    assign o_cal_hour     = r_cal_hour;
    assign o_cal_minute   = r_cal_minute;
    assign o_cal_second   = r_cal_second;

endmodule

`default_nettype wire

// File: hw/rtl/s2cd_checker.sv
// ---------------------------------------------------------------------------
// s2cd_checker
// Port-level checks of the seconds to calendar date block, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

`include "seconds_to_calendar_date_assert.svh"

module s2cd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_result_valid,
    input wire logic [3:0] o_cal_month,
    input wire logic [4:0] o_cal_day
);

    // An accepted item raises busy
    `S2CD_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted item did not raise busy")

    // Busy drops only together with a result strobe
    `S2CD_ASSERT(a_done_strobe,
                 ($fell(busy) && $past(i_rst_n)) |-> o_result_valid,
                 "busy fell without a result")

    // One result per item, never two in a row
    `S2CD_ASSERT(a_single_strobe, o_result_valid |=> !o_result_valid, "back-to-back result strobes")

    // Month stays in 1..12 and day is at least 1
    `S2CD_ASSERT(a_date_range,
                 o_result_valid |-> (o_cal_month >= 4'd1 && o_cal_month <= 4'd12 &&
                                     o_cal_day >= 5'd1),
                 "month or day out of range")

    // Reset idles the block
    `S2CD_ASSERT_ALWAYS(a_reset_idle,
                        !i_rst_n |=> (!busy && !o_result_valid),
                        "reset did not idle the block")

endmodule

bind seconds_to_calendar_date s2cd_checker u_s2cd_checker (.*);

`default_nettype wire

// File: tb/calendar_date_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// calendar_date_checker
// Watches the command, configuration and result ports of the seconds to
// calendar date block. Keeps its own copy of the epoch year, predicts the
// date of every accepted item and compares each result, field by field, with
// the oldest pending prediction.
// ---------------------------------------------------------------------------
module calendar_date_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [s2cd_pkg::YearW-1:0]  i_cfg_wr_data,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic [s2cd_pkg::DataW-1:0]  i_elapsed_seconds,
    input  logic                        i_result_valid,
    input  logic [s2cd_pkg::YearW-1:0]  i_cal_year,
    input  logic [3:0]                  i_cal_month,
    input  logic [4:0]                  i_cal_day,
    input  logic [4:0]                  i_cal_hour,
    input  logic [5:0]                  i_cal_minute,
    input  logic [5:0]                  i_cal_second,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_checked
);

    typedef struct packed {
        logic [s2cd_pkg::DataW-1:0] secs;
        logic [s2cd_pkg::YearW-1:0] epoch;
        logic [s2cd_pkg::YearW-1:0] year;
        logic [3:0]                 month;
        logic [4:0]                 day;
        logic [4:0]                 hour;
        logic [5:0]                 minute;
        logic [5:0]                 second;
    } t_cal_date;

    t_cal_date                  expected_dates[$];
    t_cal_date                  oldest_date;
    logic [s2cd_pkg::YearW-1:0] epoch_year;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        epoch_year   = s2cd_pkg::EpochReset;
    end

    // Gregorian rule: every 4th year, except centuries not divisible by 400
    function automatic bit year_is_leap(input int unsigned yr);
        return ((yr % 4) == 0 && (yr % s2cd_pkg::CenturyYears) != 0) ||
               ((yr % s2cd_pkg::Year400) == 0);
    endfunction

    // Month index 0 is January
    function automatic int unsigned month_days(input int unsigned mon, input bit leap);
        int unsigned n;
        case (mon)
            1:           n = leap ? s2cd_pkg::FebLeapDays : 28;
            3, 5, 8, 10: n = 30;
            default:     n = 31;
        endcase
        return n;
    endfunction

    // Peel off whole years, then whole months, then split the day
    function automatic t_cal_date to_calendar(input logic [s2cd_pkg::DataW-1:0] secs,
                                              input logic [s2cd_pkg::YearW-1:0] epoch);
        int unsigned rest, yr, ylen, days, mon, mlen, sod;
        bit          done;
        t_cal_date   d;
        rest = secs;
        yr   = epoch;
        ylen = year_is_leap(yr) ? s2cd_pkg::SecsLeapYear : s2cd_pkg::SecsCommonYear;
        while (rest >= ylen) begin
            rest = rest - ylen;
            yr   = yr + 1;
            ylen = year_is_leap(yr) ? s2cd_pkg::SecsLeapYear : s2cd_pkg::SecsCommonYear;
        end
        days = rest / s2cd_pkg::SecsPerDay;
        sod  = rest % s2cd_pkg::SecsPerDay;
        mon  = 0;
        done = 1'b0;
        while (!done && mon < 11) begin
            mlen = month_days(mon, year_is_leap(yr));
            if (days < mlen) begin
                done = 1'b1;
            end else begin
                days = days - mlen;
                mon  = mon + 1;
            end
        end
        d.secs   = secs;
        d.epoch  = epoch;
        d.year   = s2cd_pkg::YearW'(yr);
        d.month  = 4'(mon + 1);
        d.day    = 5'(days + 1);
        d.hour   = 5'(sod / s2cd_pkg::SecsPerHour);
        d.minute = 6'((sod % s2cd_pkg::SecsPerHour) / s2cd_pkg::SecsPerMin);
        d.second = 6'(sod % s2cd_pkg::SecsPerMin);
        return d;
    endfunction

    // Print one line per fault and count it
    task automatic report_fault(input string msg);
        $display("[%0t] calendar check: %s", $realtime, msg);
        o_fail_count = o_fail_count + 1;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want, input t_cal_date exp_d);
        if (got != want) begin
            report_fault($sformatf("%s got %0d, expected %0d (%0d s from year %0d)",
                                   name, got, want, exp_d.secs, exp_d.epoch));
        end
    endtask

    // Sample at the rising edge; the block drives with nonblocking updates
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            epoch_year = s2cd_pkg::EpochReset;
            expected_dates.delete();
        end else begin
            // Compare a result against the oldest prediction
            if (i_result_valid) begin
                if (expected_dates.size() == 0) begin
                    report_fault($sformatf("result with nothing pending (year %0d)",
                                           i_cal_year));
                end else begin
                    oldest_date = expected_dates.pop_front();
                    check_field("year",   i_cal_year,   oldest_date.year,   oldest_date);
                    check_field("month",  i_cal_month,  oldest_date.month,  oldest_date);
                    check_field("day",    i_cal_day,    oldest_date.day,    oldest_date);
                    check_field("hour",   i_cal_hour,   oldest_date.hour,   oldest_date);
                    check_field("minute", i_cal_minute, oldest_date.minute, oldest_date);
                    check_field("second", i_cal_second, oldest_date.second, oldest_date);
                    o_checked = o_checked + 1;
                end
            end
            // Predict each accepted item with the epoch in force before this edge
            if (i_start && !i_busy) begin
                expected_dates.push_back(to_calendar(i_elapsed_seconds, epoch_year));
            end
            if (i_cfg_wr_en) begin
                epoch_year = i_cfg_wr_data;
            end
        end
        o_pending = expected_dates.size();
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Drives the seconds to calendar date block: a directed set of boundary
// items, then random phases under different epoch years and sender idle
// rates. A checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module tb;
    import s2cd_pkg::*;

    localparam int CyclesLimit   = 2_000_000;
    localparam int NumPhases     = 8;
    localparam int ItemsPerPhase = 175;
    localparam int DrainEvery    = 64;
    localparam int SettleCycles  = 4;
    localparam int TailCycles    = 200;
    localparam int MaxGap        = 220;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [YearW-1:0] i_cfg_wr_data;
    logic             start;
    logic [DataW-1:0] i_elapsed_seconds;
    logic             busy;
    logic             o_result_valid;
    logic [YearW-1:0] o_cal_year;
    logic [3:0]       o_cal_month;
    logic [4:0]       o_cal_day;
    logic [4:0]       o_cal_hour;
    logic [5:0]       o_cal_minute;
    logic [5:0]       o_cal_second;

    int fail_count;
    int pending;
    int checked;
    int cycles = 0;
    int items_sent = 0;
    int epochs_used = 1;

    seconds_to_calendar_date DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .start             (start),
        .i_elapsed_seconds (i_elapsed_seconds),
        .busy              (busy),
        .o_result_valid    (o_result_valid),
        .o_cal_year        (o_cal_year),
        .o_cal_month       (o_cal_month),
        .o_cal_day         (o_cal_day),
        .o_cal_hour        (o_cal_hour),
        .o_cal_minute      (o_cal_minute),
        .o_cal_second      (o_cal_second)
    );

    calendar_date_checker date_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_start           (start),
        .i_busy            (busy),
        .i_elapsed_seconds (i_elapsed_seconds),
        .i_result_valid    (o_result_valid),
        .i_cal_year        (o_cal_year),
        .i_cal_month       (o_cal_month),
        .i_cal_day         (o_cal_day),
        .i_cal_hour        (o_cal_hour),
        .i_cal_minute      (o_cal_minute),
        .i_cal_second      (o_cal_second),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_checked         (checked)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
    end

    // Stop a hung run
    initial begin
        while (cycles < CyclesLimit) @(posedge i_clk);
        $display("Timeout after %0d cycles with %0d dates pending", cycles, pending);
        $display("** seconds_to_calendar_date: FAILED **");
        $finish;
    end

    // Drop start and hold until every pending date has come back
    task automatic drain_results();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // Write the epoch year while the block is idle
    task automatic write_epoch(input logic [YearW-1:0] yr);
        drain_results();
        repeat (SettleCycles) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= yr;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        @(negedge i_clk);
    endtask

    // Offer one item, with an optional random gap first; returns at a falling
    // edge after the item is taken, start left high
    task automatic send_item(input logic [DataW-1:0] secs, input int idle_pct);
        int gap;
        if ($urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, MaxGap);
            repeat (gap) begin
                start <= 1'b0;
                @(negedge i_clk);
            end
        end
        start             <= 1'b1;
        i_elapsed_seconds <= secs;
        // busy only moves at the rising edge, so it is stable here
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
        items_sent = items_sent + 1;
    endtask

    // Mix of full range, early years, year edges, day edges, the top end and the first day
    function automatic logic [DataW-1:0] pick_seconds();
        longint unsigned v;
        longint unsigned k;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 2 * SecsLeapYear);
            2: begin
                k = $urandom_range(1, 135);
                v = k * SecsCommonYear + (k / 4) * SecsPerDay
                    + $urandom_range(0, 4 * SecsPerDay) - 2 * SecsPerDay;
            end
            3: begin
                k = $urandom_range(0, 1) ? $urandom_range(0, 400) : $urandom_range(0, 49000);
                v = k * SecsPerDay;
                case ($urandom_range(0, 2))
                    0:       v = v;
                    1:       v = v + SecsPerDay - 1;
                    default: v = v + $urandom_range(0, SecsPerDay - 1);
                endcase
            end
            4: v = 64'hFFFF_FFFF - $urandom_range(0, 40_000_000);
            default: v = $urandom_range(0, SecsPerDay - 1);
        endcase
        return v[DataW-1:0];
    endfunction

    function automatic logic [YearW-1:0] phase_epoch(input int p);
        logic [YearW-1:0] yr;
        case (p)
            0:       yr = 14'd1970;
            1:       yr = 14'd2100;
            2:       yr = 14'd1600;
            3:       yr = 14'd9000;
            4:       yr = YearW'($urandom_range(0, 16383));
            5:       yr = 14'd16383;
            6:       yr = 14'd1899;
            default: yr = 14'd0;
        endcase
        return yr;
    endfunction

    function automatic int phase_idle(input int p);
        int pct;
        case (p % 3)
            0:       pct = 0;
            1:       pct = 75;
            default: pct = 25;
        endcase
        return pct;
    endfunction

    initial begin
        int p;
        int n;
        int idle_pct;
        i_rst_n           = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_wr_data     = '0;
        start             = 1'b0;
        i_elapsed_seconds = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset epoch: time of day edges, leap February of a 400 year, year edge, top end
        send_item(32'd0, 0);
        send_item(32'd59, 0);
        send_item(32'd60, 0);
        send_item(32'd3599, 0);
        send_item(32'd3600, 0);
        send_item(SecsPerDay - 1, 0);
        send_item(SecsPerDay, 0);
        send_item(59 * SecsPerDay - 1, 0);
        send_item(59 * SecsPerDay, 0);
        send_item(60 * SecsPerDay, 0);
        send_item(SecsLeapYear - 1, 0);
        send_item(SecsLeapYear, 0);
        send_item(32'hFFFF_FFFF, 0);
        send_item(32'h8000_0000, 0);

        // Year zero counts as leap
        write_epoch(14'd0);
        send_item(59 * SecsPerDay, 0);
        send_item(SecsLeapYear, 0);

        // Century that is not a leap year
        write_epoch(14'd1900);
        send_item(59 * SecsPerDay, 0);
        send_item(SecsCommonYear - 1, 0);

        // Top of the register range; the year field wraps past 16383
        write_epoch(14'd16383);
        send_item(32'd0, 0);
        send_item(32'hFFFF_FFFF, 0);
        epochs_used = 4;

        // Random phases, one epoch and one idle rate each
        for (p = 0; p < NumPhases; p++) begin
            write_epoch(phase_epoch(p));
            epochs_used = epochs_used + 1;
            idle_pct = phase_idle(p);
            for (n = 0; n < ItemsPerPhase; n++) begin
                if (n > 0 && (n % DrainEvery) == 0) begin
                    drain_results();
                end
                send_item(pick_seconds(), idle_pct);
            end
        end

        drain_results();
        repeat (TailCycles) @(negedge i_clk);

        $display("Converted %0d items under %0d epoch years (0 to 16383), sender idle 0/25/75%%",
                 items_sent, epochs_used);
        $display("Compared %0d dates field by field, %0d faults", checked, fail_count);
        if (fail_count == 0) begin
            $display("** seconds_to_calendar_date: PASSED **");
        end else begin
            $display("** seconds_to_calendar_date: FAILED **");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/s2cd_pkg.sv
hw/rtl/s2cd_cmp_sub.sv
hw/rtl/seconds_to_calendar_date.sv
hw/rtl/s2cd_checker.sv
tb/calendar_date_checker.sv
tb/tb.sv
